/* sv/tsg_pkg.sv */
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types and constants of the triangle span generator.
// ----------------------------------------------------------------------------
`default_nettype none
package tsg_pkg;
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int ACC_BITS   = DIFF_BITS + FRAC_BITS + 2;
   localparam int SUM_BITS   = ACC_BITS + 2;
   localparam int QUO_BITS   = DIFF_BITS + FRAC_BITS;
   localparam int CNT_BITS   = $clog2(QUO_BITS + 1);

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_ROW   = 1'b1;

   typedef struct packed {
      logic                         action;
      logic signed [COORD_BITS-1:0] vertex0_x;
      logic signed [COORD_BITS-1:0] vertex0_y;
      logic signed [COORD_BITS-1:0] vertex1_x;
      logic signed [COORD_BITS-1:0] vertex1_y;
      logic signed [COORD_BITS-1:0] vertex2_x;
      logic signed [COORD_BITS-1:0] vertex2_y;
      logic signed [COORD_BITS-1:0] offset_x;
      logic signed [COORD_BITS-1:0] offset_y;
      logic [31:0]                  fill_color;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] span_row;
      logic signed [COORD_BITS-1:0] span_x_a;
      logic signed [COORD_BITS-1:0] span_x_b;
      logic [31:0]                  span_color;
      logic                         last_span;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV_LOAD, ST_DIV_RUN, ST_DIV_STORE, ST_ROW, ST_OUT
   } state_type;

   typedef struct packed {
      logic       load_tri;
      logic       div_load;
      logic [1:0] div_sel;
      logic       div_step;
      logic       div_store;
      logic       row_step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic active;
   } sts_type;

   function automatic logic signed [COORD_BITS-1:0]
         sat_coord(input logic signed [SUM_BITS-1:0] v);
      localparam logic signed [SUM_BITS-1:0] MX = (SUM_BITS'(1) <<< (COORD_BITS-1)) - 1;
      localparam logic signed [SUM_BITS-1:0] MN = -MX - 1;
      if (v > MX) return MX[COORD_BITS-1:0];
      if (v < MN) return MN[COORD_BITS-1:0];
      return v[COORD_BITS-1:0];
   endfunction
endpackage
`default_nettype wire

/* sv/tsg_ctrl.sv */
// ----------------------------------------------------------------------------
// tsg_ctrl
// Sequencer: triangle setup with three slope divisions, then row steps.
// ----------------------------------------------------------------------------
`default_nettype none
module tsg_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_action,
   output logic                   req_ready,
   input  wire logic              out_free,
   input  wire tsg_pkg::sts_type  sts,
   output tsg_pkg::cmd_type       cmd
);
   tsg_pkg::state_type state_ff, state_in;
   logic [1:0] sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsg_pkg::ST_IDLE;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      unique case (state_ff)
         tsg_pkg::ST_IDLE:
            if (req_valid) begin
               if (req_action == tsg_pkg::ACT_START) begin
                  state_in = tsg_pkg::ST_DIV_LOAD;
                  sel_in   = 2'd0;
               end else if (sts.active && out_free) begin
                  state_in = tsg_pkg::ST_ROW;
               end
            end
         tsg_pkg::ST_DIV_LOAD:  state_in = tsg_pkg::ST_DIV_RUN;
         tsg_pkg::ST_DIV_RUN:   if (sts.div_done) state_in = tsg_pkg::ST_DIV_STORE;
         tsg_pkg::ST_DIV_STORE: begin
            if (sel_ff == 2'd2) state_in = tsg_pkg::ST_IDLE;
            else begin
               state_in = tsg_pkg::ST_DIV_LOAD;
               sel_in   = sel_ff + 2'd1;
            end
         end
         tsg_pkg::ST_ROW:       state_in = tsg_pkg::ST_OUT;
         tsg_pkg::ST_OUT:       state_in = tsg_pkg::ST_IDLE;
         default:               state_in = tsg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.div_sel = sel_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         tsg_pkg::ST_IDLE: begin
            req_ready = (req_action == tsg_pkg::ACT_START) || !sts.active || out_free;
            cmd.load_tri = req_valid && (req_action == tsg_pkg::ACT_START);
         end
         tsg_pkg::ST_DIV_LOAD:  cmd.div_load  = 1'b1;
         tsg_pkg::ST_DIV_RUN:   cmd.div_step  = 1'b1;
         tsg_pkg::ST_DIV_STORE: cmd.div_store = 1'b1;
         tsg_pkg::ST_ROW:       cmd.row_step  = 1'b1;
         tsg_pkg::ST_OUT:       cmd.out_load  = 1'b1;
         default: ;
      endcase
   end

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_tri |-> state_ff == tsg_pkg::ST_IDLE) else $error("load outside idle");
   a_row_out: assert property (@(posedge clock) disable iff (reset)
      cmd.row_step |=> cmd.out_load) else $error("row step without output");
   a_store_sel: assert property (@(posedge clock) disable iff (reset)
      cmd.div_store |-> sel_ff != 2'd3) else $error("bad slope select");
endmodule
`default_nettype wire

/* sv/tsg_dpath.sv */
// ----------------------------------------------------------------------------
// tsg_dpath
// Vertex sort, restoring slope divider, edge accumulators, span output.
// ----------------------------------------------------------------------------
`default_nettype none
module tsg_dpath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tsg_pkg::req_type  req_data,
   input  wire tsg_pkg::cmd_type  cmd,
   output tsg_pkg::sts_type       sts,
   output tsg_pkg::rsp_type       span_in
);
   localparam int CB = tsg_pkg::COORD_BITS;
   localparam int DB = tsg_pkg::DIFF_BITS;
   localparam int AB = tsg_pkg::ACC_BITS;
   localparam int SB = tsg_pkg::SUM_BITS;
   localparam int QB = tsg_pkg::QUO_BITS;
   localparam int NB = tsg_pkg::CNT_BITS;
   localparam int FB = tsg_pkg::FRAC_BITS;

   logic signed [CB-1:0] x0_ff, y0_ff, x1_ff, y1_ff, x2_ff, y2_ff;
   logic signed [CB-1:0] offx_ff, offy_ff;
   logic [31:0]          color_ff;
   logic signed [AB-1:0] slope_ff [3];
   logic signed [AB-1:0] acc_s_ff, acc_l_ff;
   logic [DB-1:0]        row_ff;
   logic                 active_ff;

   // stable sort network on y
   logic signed [CB-1:0] ax, ay, bx, by, cx, cy, tx, ty;
   always_comb begin
      ax = req_data.vertex0_x; ay = req_data.vertex0_y;
      bx = req_data.vertex1_x; by = req_data.vertex1_y;
      cx = req_data.vertex2_x; cy = req_data.vertex2_y;
      tx = ax; ty = ay;
      if (ay > by) begin tx = ax; ty = ay; ax = bx; ay = by; bx = tx; by = ty; end
      if (by > cy) begin tx = bx; ty = by; bx = cx; by = cy; cx = tx; cy = ty; end
      if (ay > by) begin tx = ax; ty = ay; ax = bx; ay = by; bx = tx; by = ty; end
   end

   // divider: magnitude restoring division, one quotient bit per cycle
   logic signed [DB-1:0] dx_sel, dy_sel;
   logic [QB-1:0] q_ff, num_ff;
   logic [DB-1:0] den_ff;
   logic [DB:0]   rem_ff, rem_try;
   logic [NB-1:0] cnt_ff;
   logic          neg_ff;
   logic [DB-1:0] dx_mag, dy_mag;
   logic signed [AB-1:0] quo_signed;

   always_comb begin
      unique case (cmd.div_sel)
         2'd0:    begin dx_sel = DB'(x1_ff) - DB'(x0_ff); dy_sel = DB'(y1_ff) - DB'(y0_ff); end
         2'd1:    begin dx_sel = DB'(x2_ff) - DB'(x0_ff); dy_sel = DB'(y2_ff) - DB'(y0_ff); end
         default: begin dx_sel = DB'(x2_ff) - DB'(x1_ff); dy_sel = DB'(y2_ff) - DB'(y1_ff); end
      endcase
      dx_mag  = dx_sel[DB-1] ? DB'(-dx_sel) : DB'(dx_sel);
      dy_mag  = dy_sel[DB-1] ? DB'(-dy_sel) : DB'(dy_sel);
      rem_try = {rem_ff[DB-1:0], num_ff[QB-1]} - {1'b0, den_ff};
      quo_signed = neg_ff ? -AB'(q_ff) : AB'(q_ff);
   end

   assign sts.div_done = (cnt_ff == NB'(QB));
   assign sts.active   = active_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         num_ff <= {dx_mag, FB'(0)};
         den_ff <= dy_mag;
         rem_ff <= '0;
         q_ff   <= '0;
         cnt_ff <= '0;
         neg_ff <= dx_sel[DB-1] ^ dy_sel[DB-1];
      end else if (cmd.div_step && !sts.div_done) begin
         num_ff <= num_ff << 1;
         cnt_ff <= cnt_ff + NB'(1);
         if (!rem_try[DB]) begin
            rem_ff <= rem_try;
            q_ff   <= {q_ff[QB-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[DB-1:0], num_ff[QB-1]};
            q_ff   <= {q_ff[QB-2:0], 1'b0};
         end
      end
   end

   // row step
   logic [DB-1:0] h1, h2;
   logic signed [AB-1:0] acc_s_in;
   assign h1 = DB'(y1_ff) - DB'(y0_ff);
   assign h2 = DB'(y2_ff) - DB'(y0_ff);
   always_comb begin
      if (row_ff < h1) acc_s_in = acc_s_ff + slope_ff[0];
      else if (row_ff == h1)
         acc_s_in = (AB'(signed'(DB'(x1_ff) - DB'(x0_ff))) <<< FB) + slope_ff[2];
      else acc_s_in = acc_s_ff + slope_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (cmd.load_tri) begin
         active_ff <= (cy != ay);
      end else if (cmd.row_step) begin
         if (row_ff + DB'(1) >= h2) active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_tri) begin
         x0_ff <= ax; y0_ff <= ay; x1_ff <= bx; y1_ff <= by; x2_ff <= cx; y2_ff <= cy;
         offx_ff  <= req_data.offset_x;
         offy_ff  <= req_data.offset_y;
         color_ff <= req_data.fill_color;
         acc_s_ff <= '0;
         acc_l_ff <= '0;
         row_ff   <= '0;
      end else if (cmd.row_step) begin
         acc_s_ff <= acc_s_in;
         acc_l_ff <= acc_l_ff + slope_ff[1];
      end else if (cmd.out_load) begin
         row_ff <= row_ff + DB'(1);
      end
      if (cmd.div_store) slope_ff[cmd.div_sel] <= (den_ff == '0) ? '0 : quo_signed;
   end

   // span output from stepped accumulators; row still holds this span's index
   logic signed [SB-1:0] base, sa, sl, rsum;
   always_comb begin
      base = (SB'(offx_ff) + SB'(x0_ff)) <<< FB;
      sa   = base + SB'(acc_s_ff);
      sl   = base + SB'(acc_l_ff);
      rsum = SB'(offy_ff) + SB'(y0_ff) + SB'(signed'({1'b0, row_ff}));
      span_in.span_row   = tsg_pkg::sat_coord(rsum);
      span_in.span_x_a   = tsg_pkg::sat_coord(sa >>> FB);
      span_in.span_x_b   = tsg_pkg::sat_coord(sl >>> FB);
      span_in.span_color = color_ff;
      span_in.last_span  = (row_ff == h2 - DB'(1));
   end

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      cmd.div_store |-> sts.div_done) else $error("slope stored early");
   a_row_act: assert property (@(posedge clock) disable iff (reset)
      cmd.row_step |-> active_ff) else $error("row step with no triangle");
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      cmd.row_step |-> row_ff < h2) else $error("row past end");
endmodule
`default_nettype wire

/* sv/triangle_span_generator_unit.sv */
// ----------------------------------------------------------------------------
// triangle_span_generator_unit
// Scanline triangle fill: one span item per row item while a triangle is active.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req_    | in  | req_valid/req_ready  | tsg_pkg::req_type
//  rsp_    | out | rsp_valid/rsp_ready  | tsg_pkg::rsp_type
//
// A start item runs three slope divisions through one restoring divider, one
// quotient bit per cycle; each division passes through a load state, the run
// state and a store state.
// A row item passes through accept, accumulator step and span register load.
// While a triangle is active, a row is accepted only if the span register is
// empty or drains in that cycle; else it waits until the held item is taken.
// Synchronous active-high reset clears the sequencer, active flag and output valid flag.
`default_nettype none
module triangle_span_generator_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tsg_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tsg_pkg::rsp_type       rsp_data
);
   tsg_pkg::cmd_type cmd;
   tsg_pkg::sts_type sts;
   tsg_pkg::rsp_type span_in;
   logic             rsp_valid_ff;
   tsg_pkg::rsp_type rsp_data_ff;
   logic             out_free;

   // a row may start only if the output register empties before out_load
   assign out_free = !rsp_valid_ff || rsp_ready;

   tsg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_ready  (req_ready),
      .out_free   (out_free),
      .sts        (sts),
      .cmd        (cmd)
   );

   tsg_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .span_in  (span_in)
   );

   // out_load follows acceptance through ST_ROW into ST_OUT; the register was free
   // then and stays free or drains, so only a taken item may linger: block on it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) rsp_data_ff <= span_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid_ff) else $error("span register overwritten");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("span dropped");
   a_ready_setup: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !req_ready) else $error("ready during setup");
endmodule
`default_nettype wire

/* tb/sv/triangle_span_generator_unit_tb.sv */
// ----------------------------------------------------------------------------
// triangle_span_generator_unit_tb
// Directed and randomized check of the span generator: start and row items
// go in through valid/ready, spans are predicted in fixed point and compared
// in order by a small scoreboard, under several sender/receiver idle mixes.
// ----------------------------------------------------------------------------
`default_nettype none

// Span predictor and store of expected spans.
class span_board;
   typedef longint signed wide_type;

   wide_type vx[3], vy[3];
   wide_type slope_a, slope_b, slope_c;
   wide_type acc_short, acc_long;
   wide_type row_idx;
   wide_type off_x, off_y;
   logic [31:0] color;
   bit active;
   tsg_pkg::rsp_type pending[$];
   int errors;

   function new();
      active = 0; errors = 0; row_idx = 0;
      acc_short = 0; acc_long = 0;
      slope_a = 0; slope_b = 0; slope_c = 0;
      off_x = 0; off_y = 0; color = '0;
      foreach (vx[i]) begin
         vx[i] = 0; vy[i] = 0;
      end
   endfunction

   function wide_type slope_q(wide_type dx, wide_type dy);
      wide_type q;
      if (dy == 0) return 0;
      q = (dx <<< tsg_pkg::FRAC_BITS) / dy;   // SV division truncates toward zero
      return q;
   endfunction

   function logic [15:0] clamp(wide_type v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function wide_type flr(wide_type v);
      return v >>> tsg_pkg::FRAC_BITS;   // arithmetic shift = floor
   endfunction

   // Note an accepted item; queue the span it produces, if any.
   function void note_item(tsg_pkg::req_type r);
      wide_type t, h1, h2, base;
      tsg_pkg::rsp_type s;
      if (r.action == tsg_pkg::ACT_START) begin
         vx[0] = r.vertex0_x; vy[0] = r.vertex0_y;
         vx[1] = r.vertex1_x; vy[1] = r.vertex1_y;
         vx[2] = r.vertex2_x; vy[2] = r.vertex2_y;
         // stable sort by y
         for (int k = 0; k < 2; k++)
            for (int i = 0; i < 2; i++)
               if (vy[i] > vy[i+1]) begin
                  t = vx[i]; vx[i] = vx[i+1]; vx[i+1] = t;
                  t = vy[i]; vy[i] = vy[i+1]; vy[i+1] = t;
               end
         slope_a = slope_q(vx[1] - vx[0], vy[1] - vy[0]);
         slope_b = slope_q(vx[2] - vx[0], vy[2] - vy[0]);
         slope_c = slope_q(vx[2] - vx[1], vy[2] - vy[1]);
         acc_short = 0; acc_long = 0; row_idx = 0;
         off_x = r.offset_x; off_y = r.offset_y;
         color = r.fill_color;
         active = (vy[2] != vy[0]);
         return;
      end
      if (!active) return;
      h1 = vy[1] - vy[0];
      h2 = vy[2] - vy[0];
      if (row_idx < h1) acc_short += slope_a;
      else begin
         if (row_idx == h1) acc_short = (vx[1] - vx[0]) <<< tsg_pkg::FRAC_BITS;
         acc_short += slope_c;
      end
      acc_long += slope_b;
      base = (off_x + vx[0]) <<< tsg_pkg::FRAC_BITS;
      s.span_row   = clamp(off_y + vy[0] + row_idx);
      s.span_x_a   = clamp(flr(base + acc_short));
      s.span_x_b   = clamp(flr(base + acc_long));
      s.span_color = color;
      s.last_span  = (row_idx == h2 - 1);
      pending.push_back(s);
      row_idx++;
      if (row_idx >= h2) active = 0;
   endfunction

   // Compare one accepted span with the oldest expectation.
   function void check_span(tsg_pkg::rsp_type got);
      tsg_pkg::rsp_type exp_s;
      if (pending.size() == 0) begin
         $display("%0t: unexpected span, actual %h", $time, got);
         errors++;
         return;
      end
      exp_s = pending.pop_front();
      if (got.span_row !== exp_s.span_row)
         $display("%0t: span_row expected %0d actual %0d", $time,
                  exp_s.span_row, got.span_row);
      if (got.span_x_a !== exp_s.span_x_a)
         $display("%0t: span_x_a expected %0d actual %0d", $time,
                  exp_s.span_x_a, got.span_x_a);
      if (got.span_x_b !== exp_s.span_x_b)
         $display("%0t: span_x_b expected %0d actual %0d", $time,
                  exp_s.span_x_b, got.span_x_b);
      if (got.span_color !== exp_s.span_color)
         $display("%0t: span_color expected %h actual %h", $time,
                  exp_s.span_color, got.span_color);
      if (got.last_span !== exp_s.last_span)
         $display("%0t: last_span expected %b actual %b", $time,
                  exp_s.last_span, got.last_span);
      if (got !== exp_s) errors++;
   endfunction
endclass

module triangle_span_generator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   tsg_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   tsg_pkg::rsp_type rsp_data;

   span_board board = new();

   int send_idle_pct = 0;   // sender idle chance per cycle, percent
   int recv_stall_pct = 0;  // receiver stall chance per cycle, percent
   bit recv_hold = 0;       // long receiver hold-off in progress

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   triangle_span_generator_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Accepted items feed the predictor; accepted spans get checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_item(req_data);
         if (rsp_valid && rsp_ready) board.check_span(rsp_data);
      end
   end

   // Receiver: ready changes at the falling edge.
   always @(negedge clock) begin
      if (reset || recv_hold) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Offer one item, with random idle gaps ahead of it. Valid stays high
   // after acceptance so the next item can follow at once; idle gaps and
   // drain() drop it.
   task automatic send_item(input tsg_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_coord(input int spread);
      case ($urandom_range(9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'($urandom);
         default: return 16'($signed($urandom_range(2 * spread)) - spread);
      endcase
   endfunction

   function automatic tsg_pkg::req_type start_item(input int spread, input int hspread);
      tsg_pkg::req_type r;
      r = '0;
      r.action    = tsg_pkg::ACT_START;
      r.vertex0_x = rand_coord(spread);
      r.vertex1_x = rand_coord(spread);
      r.vertex2_x = rand_coord(spread);
      // keep heights small most of the time so triangles finish
      r.vertex0_y = 16'($signed($urandom_range(2 * hspread)) - hspread);
      r.vertex1_y = 16'($signed($urandom_range(2 * hspread)) - hspread);
      r.vertex2_y = 16'($signed($urandom_range(2 * hspread)) - hspread);
      if ($urandom_range(15) == 0) r.vertex1_y = 16'($urandom);
      r.offset_x   = ($urandom_range(7) == 0) ? 16'($urandom) : rand_coord(200);
      r.offset_y   = ($urandom_range(7) == 0) ? 16'($urandom) : rand_coord(200);
      r.fill_color = $urandom;
      return r;
   endfunction

   function automatic tsg_pkg::req_type row_item();
      tsg_pkg::req_type r;
      r = '0;
      r.action = tsg_pkg::ACT_ROW;
      r.vertex0_x = 16'($urandom); r.vertex0_y = 16'($urandom); // ignored noise
      r.fill_color = $urandom;
      return r;
   endfunction

   // Called at a falling edge: stop offering, wait for every span.
   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock);
   endtask

   // One triangle: start plus its rows, with sometimes extra or early stops.
   task automatic run_triangle(input int spread, input int hspread);
      tsg_pkg::req_type r;
      int rows;
      r = start_item(spread, hspread);
      send_item(r);
      rows = board.active ? int'(board.vy[2] - board.vy[0]) : 0;
      if (rows > 60) rows = 60 + $urandom_range(3);
      case ($urandom_range(9))
         0: rows = rows + $urandom_range(1, 3);      // rows past the end
         1: rows = $urandom_range(rows);             // cut short by restart
         default: ;
      endcase
      repeat (rows) send_item(row_item());
   endtask

   initial begin
      tsg_pkg::req_type r;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed part
      send_item(row_item());                         // row with no triangle
      r = '0; r.action = tsg_pkg::ACT_START;         // flat triangle
      r.vertex0_x = 3; r.vertex1_x = 9; r.vertex2_x = -4;
      r.vertex0_y = 5; r.vertex1_y = 5; r.vertex2_y = 5;
      r.fill_color = 32'hffffffff;
      send_item(r);
      send_item(row_item());
      r.vertex0_x = 16'sh7fff; r.vertex0_y = 16'sh8000;   // extremes
      r.vertex1_x = 16'sh8000; r.vertex1_y = 0;
      r.vertex2_x = 16'sh7fff; r.vertex2_y = 16'sh8003;
      r.offset_x = 16'sh7fff; r.offset_y = 16'sh7fff;
      r.fill_color = 32'h0;
      send_item(r);
      repeat (4) send_item(row_item());
      r.vertex0_x = 0; r.vertex0_y = 0;              // equal y, order kept
      r.vertex1_x = 10; r.vertex1_y = 0;
      r.vertex2_x = 5; r.vertex2_y = 6;
      r.offset_x = 16'sh8000; r.offset_y = 16'sh8000;
      r.fill_color = 32'h12345678;
      send_item(r);
      repeat (7) send_item(row_item());
      r.vertex0_x = -7; r.vertex0_y = 4;             // flat bottom, reversed input
      r.vertex1_x = 20; r.vertex1_y = 4;
      r.vertex2_x = 1;  r.vertex2_y = -3;
      r.offset_x = 0; r.offset_y = 0;
      send_item(r);
      repeat (3) send_item(row_item());
      r.vertex2_y = 10;                              // restart mid-triangle
      send_item(r);
      repeat (6) send_item(row_item());
      drain();

      // random phases: none, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 58 : (ph == 3) ? 19 : 0;
         recv_stall_pct = (ph == 2) ? 58 : (ph == 3) ? 19 : 0;
         for (int n = 0; n < 300; ) begin
            run_triangle(($urandom_range(3) == 0) ? 32767 : 300,
                         ($urandom_range(5) == 0) ? 60 : 8);
            n += 1 + int'(board.row_idx);
            if ($urandom_range(15) == 0) drain();   // sender waits for all spans
         end
         // long receiver hold-off while rows keep coming; the rows cannot
         // all pass before the hold ends, so the sender finishes last
         fork
            begin
               recv_hold = 1;
               repeat (300) @(negedge clock);
               recv_hold = 0;
            end
            begin
               r = start_item(100, 0);
               r.vertex0_y = 0; r.vertex1_y = 20; r.vertex2_y = 40;
               send_item(r);
               repeat (40) send_item(row_item());
            end
         join
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule

`default_nettype wire

/* files.f */
sv/tsg_pkg.sv
sv/tsg_ctrl.sv
sv/tsg_dpath.sv
sv/triangle_span_generator_unit.sv
tb/sv/triangle_span_generator_unit_tb.sv
